FILE: src/bap_pkg.sv
// Shared types, widths and constants of the block-average pixelation unit.
package bap_pkg;

  // Field and register widths.
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned SUM_W     = 14;
  localparam int unsigned CFG_IDX_W = 1;

  // Default geometry limits and the fixed height limit.
  localparam int unsigned BLOCK_SIZE_DEF = 8;
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT     = 4096;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Register values after reset.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Control that the sequencer sends to all three channel lanes at once.
  typedef struct packed {
    logic rd_en;      // read the tile-column sum, capture the pixel
    logic acc;        // add the pixel and write the sum back
    logic first;      // pixel opens a tile: the sum restarts
    logic div_start;  // load the divider with the new sum
    logic div_step;   // one quotient bit
  } lane_ctl_t;

  // Command that starts the emission of one tile.
  typedef struct packed {
    logic start;
    pos_t x0;
    pos_t y0;
    pos_t xe;
    pos_t ye;
  } emit_cmd_t;

endpackage

FILE: src/bap_ifs.sv
// Valid/ready channel interfaces for pixel items and result items.
interface bap_pix_if import bap_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface bap_res_if import bap_pkg::*; ();
  logic  valid;
  logic  ready;
  pos_t  out_x;
  pos_t  out_y;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic  block_done;

  modport source (output valid, output out_x, output out_y, output out_red, output out_green,
                  output out_blue, output block_done, input ready);
  modport sink (input valid, input out_x, input out_y, input out_red, input out_green,
                input out_blue, input block_done, output ready);
endinterface

FILE: src/bap_lane.sv
// One colour channel lane: tile-column sum store, accumulator and serial divider.
module bap_lane import bap_pkg::*; #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned CNT_W = 7
) (
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  chan_t                    pix,
  input  logic [CNT_W-1:0]         count,
  output chan_t                    avg
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  sum_t               mem [DEPTH];
  sum_t               rd_r;
  chan_t              pix_r;
  logic [IDX_W-1:0]   addr_r;
  sum_t               acc_sum;

  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   rem_nxt;
  logic [CNT_W-1:0]   dvs_r;
  sum_t               quo_r;
  logic [CNT_W+1:0]   shifted;
  logic [CNT_W+1:0]   diff;
  logic               ge;

  // The first pixel of a tile overwrites the sum; later ones add to it.
  assign acc_sum = ctl.first ? SUM_W'(pix_r) : rd_r + SUM_W'(pix_r);

  // Sum store: read when an item is accepted, written back in the cycle after.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_r   <= mem[addr];
      addr_r <= addr;
      pix_r  <= pix;
    end
    if (ctl.acc) begin
      mem[addr_r] <= acc_sum;
    end
  end

  // Restoring division, one quotient bit per cycle.
  assign shifted = {1'b0, rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted - {2'b00, dvs_r};
  assign ge      = !diff[CNT_W+1];
  assign rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem_r <= '0;
      quo_r <= acc_sum;
      dvs_r <= count;
    end else if (ctl.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  // A quotient above the channel range saturates.
  assign avg = (|quo_r[SUM_W-1:CHAN_W]) ? '1 : quo_r[CHAN_W-1:0];

endmodule

FILE: src/bap_emit.sv
// Merging stage: walks the finished tile and drives the result output register.
module bap_emit import bap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  emit_cmd_t  cmd,
  input  chan_t      mean_red,
  input  chan_t      mean_green,
  input  chan_t      mean_blue,
  output logic       busy,
  bap_res_if.source  out_res
);

  logic  active_r;
  logic  valid_r;
  pos_t  px_r;
  pos_t  py_r;
  pos_t  xs_r;
  pos_t  xe_r;
  pos_t  ye_r;
  pos_t  out_x_r;
  pos_t  out_y_r;
  chan_t out_red_r;
  chan_t out_green_r;
  chan_t out_blue_r;
  logic  done_r;
  logic  load;
  logic  at_end;

  // A new item enters the output register when it is empty or being taken.
  assign load   = active_r && (!valid_r || out_res.ready);
  assign at_end = (px_r == xe_r) && (py_r == ye_r);
  assign busy   = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        active_r <= 1'b1;
      end else if (load && at_end) begin
        active_r <= 1'b0;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_res.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Row-major walk over the tile.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= cmd.x0;
      py_r <= cmd.y0;
      xs_r <= cmd.x0;
      xe_r <= cmd.xe;
      ye_r <= cmd.ye;
    end else if (load) begin
      if (px_r == xe_r) begin
        px_r <= xs_r;
        py_r <= py_r + POS_W'(1);
      end else begin
        px_r <= px_r + POS_W'(1);
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r     <= px_r;
      out_y_r     <= py_r;
      out_red_r   <= mean_red;
      out_green_r <= mean_green;
      out_blue_r  <= mean_blue;
      done_r      <= at_end;
    end
  end

  assign out_res.valid      = valid_r;
  assign out_res.out_x      = out_x_r;
  assign out_res.out_y      = out_y_r;
  assign out_res.out_red    = out_red_r;
  assign out_res.out_green  = out_green_r;
  assign out_res.out_blue   = out_blue_r;
  assign out_res.block_done = done_r;

endmodule

FILE: src/block_average_pixelate_unit.sv
// Top level of the block-average pixelation unit: position tracking and sequencing.
//
// Pixels arrive in raster order on in_pix (valid/ready); each accepted item is
// one RGB pixel. The image is cut into BLOCK_SIZE square tiles, clipped at the
// right and bottom edges. When a tile's bottom-right pixel arrives, every pixel
// of the tile is sent on out_res in row-major order with the tile's truncated
// average colour; block_done marks the last one.
// A pixel that does not end a tile reads its tile-column sum when accepted
// and writes it back from the S_ACC state. A tile-ending pixel then runs the
// divider (one quotient bit per cycle, the three channel lanes side by side),
// and its tile's results go out once the division ends. Results then leave at
// one per cycle while out_res.ready is high; the next pixel can be taken once
// the emitter and the sequencer are idle after the last result of the tile.
// A stall on out_res holds the current result and pauses the tile walk.
// The configuration port (cfg_we, cfg_index, cfg_data) sets image width and
// height; write it only while the unit is idle. Reset sets 640 x 480 and the
// position to the top-left pixel. The sum store is not cleared: the first
// pixel of each tile overwrites its entry.
module block_average_pixelate_unit import bap_pkg::*; #(
  parameter int unsigned BLOCK_SIZE = BLOCK_SIZE_DEF,
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  bap_pix_if.sink              in_pix,
  bap_res_if.source            out_res
);

  localparam int unsigned TILE_COLS = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned IDX_W     = $clog2(TILE_COLS);
  localparam int unsigned OFF_W     = $clog2(BLOCK_SIZE);
  localparam int unsigned CNT_W     = $clog2(BLOCK_SIZE * BLOCK_SIZE + 1);
  localparam int unsigned DCNT_W    = $clog2(SUM_W);
  localparam logic [OFF_W-1:0]  OFF_LAST = OFF_W'(BLOCK_SIZE - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [DCNT_W-1:0] div_cnt_r;

  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;

  pos_t              col_r;
  pos_t              row_r;
  logic [OFF_W-1:0]  xoff_r;
  logic [OFF_W-1:0]  yoff_r;
  logic [IDX_W-1:0]  tc_r;
  pos_t              col_nxt;
  pos_t              row_nxt;
  logic [OFF_W-1:0]  xoff_nxt;
  logic [OFF_W-1:0]  yoff_nxt;
  logic [IDX_W-1:0]  tc_nxt;

  logic              col_wrap;
  logic              row_wrap;
  logic [DIM_W-1:0]  row_inc;
  logic [OFF_W-1:0]  yoff_inc;
  pos_t              nx;
  pos_t              ny;
  logic [OFF_W-1:0]  nxoff;
  logic [OFF_W-1:0]  nyoff;
  logic [IDX_W-1:0]  ntc;
  logic              x_end;
  logic              y_end;
  logic              xo_end;
  logic              yo_end;

  pos_t              it_x_r;
  pos_t              it_y_r;
  logic [OFF_W-1:0]  it_xoff_r;
  logic [OFF_W-1:0]  it_yoff_r;
  logic              it_first_r;
  logic              it_last_r;

  logic              in_fire;
  logic [CNT_W-1:0]  tile_w;
  logic [CNT_W-1:0]  tile_h;
  logic [CNT_W-1:0]  count;
  lane_ctl_t         ctl;
  emit_cmd_t         cmd;
  chan_t             mean_red;
  chan_t             mean_green;
  chan_t             mean_blue;
  logic              emit_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  // Effective geometry: zero counts as one, oversize is clamped.
  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Bring the stored position inside the current geometry.
  always_comb begin
    col_wrap = {1'b0, col_r} >= w_eff;
    row_inc  = col_wrap ? {1'b0, row_r} + DIM_W'(1) : {1'b0, row_r};
    yoff_inc = yoff_r;
    if (col_wrap) begin
      yoff_inc = (yoff_r == OFF_LAST) ? '0 : yoff_r + OFF_W'(1);
    end
    row_wrap = row_inc >= h_eff;
    nx       = col_wrap ? '0 : col_r;
    nxoff    = col_wrap ? '0 : xoff_r;
    ntc      = col_wrap ? '0 : tc_r;
    ny       = row_wrap ? '0 : row_inc[POS_W-1:0];
    nyoff    = row_wrap ? '0 : yoff_inc;
  end

  // Tile edges seen by this pixel, and the position of the next one.
  always_comb begin
    x_end  = ({1'b0, nx} + DIM_W'(1)) == w_eff;
    y_end  = ({1'b0, ny} + DIM_W'(1)) == h_eff;
    xo_end = nxoff == OFF_LAST;
    yo_end = nyoff == OFF_LAST;
    if (x_end) begin
      col_nxt  = '0;
      xoff_nxt = '0;
      tc_nxt   = '0;
      row_nxt  = y_end ? '0 : ny + POS_W'(1);
      yoff_nxt = (y_end || yo_end) ? '0 : nyoff + OFF_W'(1);
    end else begin
      col_nxt  = nx + POS_W'(1);
      xoff_nxt = xo_end ? '0 : nxoff + OFF_W'(1);
      tc_nxt   = xo_end ? ntc + IDX_W'(1) : ntc;
      row_nxt  = ny;
      yoff_nxt = nyoff;
    end
  end

  assign in_fire      = in_pix.valid && in_pix.ready;
  assign in_pix.ready = state_r == S_IDLE;

  // Position and item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      xoff_r <= '0;
      yoff_r <= '0;
      tc_r   <= '0;
    end else if (in_fire) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      xoff_r <= xoff_nxt;
      yoff_r <= yoff_nxt;
      tc_r   <= tc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_x_r     <= nx;
      it_y_r     <= ny;
      it_xoff_r  <= nxoff;
      it_yoff_r  <= nyoff;
      it_first_r <= (nxoff == '0) && (nyoff == '0);
      it_last_r  <= (xo_end || x_end) && (yo_end || y_end);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = it_last_r ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_cnt_r == DIV_LAST) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!emit_busy) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + DCNT_W'(1);
      end else begin
        div_cnt_r <= '0;
      end
    end
  end

  // The pixel ending a tile is its bottom-right corner, so the tile size
  // follows from its offsets.
  assign tile_w = CNT_W'(it_xoff_r) + CNT_W'(1);
  assign tile_h = CNT_W'(it_yoff_r) + CNT_W'(1);
  assign count  = tile_w * tile_h;

  assign ctl.rd_en     = in_fire;
  assign ctl.acc       = state_r == S_ACC;
  assign ctl.first     = it_first_r;
  assign ctl.div_start = (state_r == S_ACC) && it_last_r;
  assign ctl.div_step  = state_r == S_DIV;

  assign cmd.start = (state_r == S_DIV) && (div_cnt_r == DIV_LAST);
  assign cmd.x0    = it_x_r - POS_W'(it_xoff_r);
  assign cmd.y0    = it_y_r - POS_W'(it_yoff_r);
  assign cmd.xe    = it_x_r;
  assign cmd.ye    = it_y_r;

  // Channel lanes.
  bap_lane #(.DEPTH(TILE_COLS), .CNT_W(CNT_W)) u_lane_red (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (ntc),
    .pix   (in_pix.in_red),
    .count (count),
    .avg   (mean_red)
  );

  bap_lane #(.DEPTH(TILE_COLS), .CNT_W(CNT_W)) u_lane_green (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (ntc),
    .pix   (in_pix.in_green),
    .count (count),
    .avg   (mean_green)
  );

  bap_lane #(.DEPTH(TILE_COLS), .CNT_W(CNT_W)) u_lane_blue (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (ntc),
    .pix   (in_pix.in_blue),
    .count (count),
    .avg   (mean_blue)
  );

  // Merging stage and output register.
  bap_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .mean_red   (mean_red),
    .mean_green (mean_green),
    .mean_blue  (mean_blue),
    .busy       (emit_busy),
    .out_res    (out_res)
  );

endmodule

FILE: src/bap_checker.sv
// Port-level assertions for the pixelation unit and the bind that attaches them.
module bap_checker import bap_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input pos_t  out_x,
  input pos_t  out_y,
  input chan_t out_red,
  input chan_t out_green,
  input chan_t out_blue,
  input logic  out_block_done
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_block_done))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // An accepted pixel blocks the next one while its sum is written back.
  a_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted in back-to-back cycles");

  // While a tile is still being sent, no new pixel is taken.
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_block_done |-> !in_ready)
    else $error("pixel accepted in the middle of a tile");

endmodule

bind block_average_pixelate_unit bap_checker u_bap_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pix.valid),
  .in_ready       (in_pix.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_x          (out_res.out_x),
  .out_y          (out_res.out_y),
  .out_red        (out_res.out_red),
  .out_green      (out_res.out_green),
  .out_blue       (out_res.out_blue),
  .out_block_done (out_res.block_done)
);

FILE: verif/block_average_pixelate_unit_tb.sv
// Self-checking testbench of the block-average pixelation unit with its own tile predictor.
module block_average_pixelate_unit_tb;
  import bap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BS          = BLOCK_SIZE_DEF;
  localparam int TILE_COLS   = (MAX_WIDTH_DEF + BS - 1) / BS;
  localparam int RANDOM_ITEMS = 40;
  localparam int IDLE_PAUSE  = 20;
  localparam int LIMIT_NS    = 2_000_000;

  // One emitted pixel of a finished tile.
  typedef struct packed {
    pos_t  x;
    pos_t  y;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  done;
  } tile_px_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  bap_pix_if pix ();
  bap_res_if res ();

  block_average_pixelate_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (pix),
    .out_res   (res)
  );

  // Predictor state: geometry registers, next pixel position and per-column sums.
  logic [DIM_W-1:0]     width_reg  = WIDTH_RST;
  logic [DIM_W-1:0]     height_reg = HEIGHT_RST;
  int                   col_pos    = 0;
  int                   row_pos    = 0;
  sum_t                 red_sum   [TILE_COLS];
  sum_t                 green_sum [TILE_COLS];
  sum_t                 blue_sum  [TILE_COLS];
  bit [TILE_COLS-1:0]   col_written = '0;
  tile_px_t             pending_tile_px [$];
  int                   errors = 0;
  bit                   steady_flow = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #(LIMIT_NS);
    $display("** block_average_pixelate_unit: FAILED **");
    $finish;
  end

  // Clamp a geometry register to its usable range.
  function automatic int effective_dim(input logic [DIM_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Truncating tile average that saturates at full scale.
  function automatic chan_t tile_average(input sum_t total, input int count);
    int q;
    q = int'(total) / count;
    return (q > 255) ? 8'hFF : chan_t'(q);
  endfunction

  // Mostly random channel values, with the extremes favoured.
  function automatic chan_t pick_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // A new geometry must never make the unit read a column sum that was never written.
  function automatic bit geometry_is_safe(input logic [DIM_W-1:0] wv, input logic [DIM_W-1:0] hv);
    int w, h, x, y, c;
    w = effective_dim(wv, MAX_WIDTH_DEF);
    h = effective_dim(hv, MAX_HEIGHT);
    x = col_pos;
    y = row_pos;
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    if (x == 0 && y % BS == 0) return 1'b1;
    for (c = 0; c <= (w - 1) / BS; c++) begin
      if (!col_written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Fold one accepted pixel into its tile and queue the tile's pixels when it closes.
  task automatic accumulate_pixel(input chan_t r, input chan_t g, input chan_t b);
    int w, h, x, y, tc, x0, y0, x1, y1, count, px, py;
    chan_t avg_r, avg_g, avg_b;
    tile_px_t item;
    w = effective_dim(width_reg, MAX_WIDTH_DEF);
    h = effective_dim(height_reg, MAX_HEIGHT);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    x  = col_pos;
    y  = row_pos;
    tc = x / BS;
    x0 = tc * BS;
    y0 = (y / BS) * BS;
    x1 = (x0 + BS > w) ? w : x0 + BS;
    y1 = (y0 + BS > h) ? h : y0 + BS;

    // The first pixel of a tile restarts the column sums; the rest add and wrap.
    if (x == x0 && y == y0) begin
      red_sum[tc]   = sum_t'(r);
      green_sum[tc] = sum_t'(g);
      blue_sum[tc]  = sum_t'(b);
      col_written[tc] = 1'b1;
    end else begin
      red_sum[tc]   = red_sum[tc] + sum_t'(r);
      green_sum[tc] = green_sum[tc] + sum_t'(g);
      blue_sum[tc]  = blue_sum[tc] + sum_t'(b);
    end

    // The bottom-right pixel closes the tile: every pixel of it goes out in row-major order.
    if (x + 1 == x1 && y + 1 == y1) begin
      count = (x1 - x0) * (y1 - y0);
      avg_r = tile_average(red_sum[tc], count);
      avg_g = tile_average(green_sum[tc], count);
      avg_b = tile_average(blue_sum[tc], count);
      for (py = y0; py < y1; py++) begin
        for (px = x0; px < x1; px++) begin
          item.x     = pos_t'(px);
          item.y     = pos_t'(py);
          item.red   = avg_r;
          item.green = avg_g;
          item.blue  = avg_b;
          item.done  = (px + 1 == x1 && py + 1 == y1);
          pending_tile_px.push_back(item);
        end
      end
    end

    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Send one pixel item, sometimes after a short gap, and predict it on acceptance.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    if (!steady_flow && $urandom_range(0, 99) < 10) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.in_red   <= r;
    pix.in_green <= g;
    pix.in_blue  <= b;
    do @(posedge clk); while (!pix.ready);
    accumulate_pixel(r, g, b);
  endtask

  // Let every expected pixel arrive and the last input finish before touching registers.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (pending_tile_px.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Write both geometry registers on back-to-back cycles.
  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  function automatic void compare_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      errors++;
    end
  endfunction

  // Result sink: stalls about one cycle in ten, except during steady stretches.
  initial begin
    res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      res.ready <= steady_flow || ($urandom_range(0, 99) >= 10);
    end
  end

  // Compare every accepted result item with the oldest predicted one.
  initial begin
    tile_px_t want;
    forever begin
      @(posedge clk);
      if (rst_n && res.valid && res.ready) begin
        if (pending_tile_px.size() == 0) begin
          $display("%0t ns: unexpected item x=%0d y=%0d rgb=%0d,%0d,%0d done=%0d", $time,
                   res.out_x, res.out_y, res.out_red, res.out_green, res.out_blue,
                   res.block_done);
          errors++;
        end else begin
          want = pending_tile_px.pop_front();
          compare_field("out_x", int'(want.x), int'(res.out_x));
          compare_field("out_y", int'(want.y), int'(res.out_y));
          compare_field("out_red", int'(want.red), int'(res.out_red));
          compare_field("out_green", int'(want.green), int'(res.out_green));
          compare_field("out_blue", int'(want.blue), int'(res.out_blue));
          compare_field("block_done", int'(want.done), int'(res.block_done));
        end
      end
    end
  end

  // Pixels under the 640 x 480 reset geometry close no tile.
  task automatic test_reset_geometry();
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  // A zero geometry acts as 1 x 1, so every pixel is its own tile.
  task automatic test_unit_tiles();
    wait_idle();
    set_geometry(13'd0, 13'd0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'h0F);
    send_pixel(8'h55, 8'hAA, 8'hF0);
    wait_idle();
    set_geometry(13'd1, 13'd1);
    send_pixel(8'h01, 8'h80, 8'h7F);
  endtask

  // A 3 x 2 image is one clipped tile whose averages truncate.
  task automatic test_clipped_tile();
    int k;
    wait_idle();
    set_geometry(13'd3, 13'd2);
    for (k = 0; k < 6; k++) begin
      send_pixel(8'hFF, (k == 0) ? 8'd1 : 8'd0, chan_t'(200 + k));
    end
  endtask

  // Widest and tallest geometry, oversize values, and a narrowing in the middle of a row.
  task automatic test_extreme_geometry();
    wait_idle();
    set_geometry(13'd4096, 13'h1FFF);
    send_pixel(8'd10, 8'd20, 8'd30);
    send_pixel(8'd40, 8'd50, 8'd60);
    send_pixel(8'd70, 8'd80, 8'd90);
    wait_idle();
    set_geometry(13'd4, 13'd1);
    send_pixel(8'd100, 8'd110, 8'd120);
    wait_idle();
    set_geometry(13'h1FFF, 13'd1);
    repeat (8) send_pixel(8'hFF, 8'hFF, pick_channel());
  endtask

  // Stale sums carried into a smaller tile push the average past full scale.
  task automatic test_average_saturation();
    wait_idle();
    set_geometry(13'd2, 13'd2);
    send_pixel(8'hFF, 8'h00, 8'h80);
    send_pixel(8'hFF, 8'h00, 8'h80);
  endtask

  // A row wrap after a height cut keeps the column sum, which then wraps past 14 bits.
  // The first part runs as a long stretch with no idling on either side.
  task automatic test_sum_wrap();
    wait_idle();
    set_geometry(13'd8, 13'd16);
    steady_flow = 1'b1;
    repeat (63) send_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    steady_flow = 1'b0;
    set_geometry(13'd8, 13'd2);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    set_geometry(13'd1, 13'd2);
    send_pixel(8'hFF, 8'hFE, 8'h01);
  endtask

  // Random images of mostly small geometry, changed between bursts of pixels.
  task automatic test_random_images();
    int sent, phase, n, tries;
    logic [DIM_W-1:0] w, h;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      steady_flow = (phase % 5 == 2);
      tries = 0;
      do begin
        case ($urandom_range(0, 9))
          8: begin
            w = ($urandom_range(0, 2) == 0) ? 13'h1FFF :
                ($urandom_range(0, 1) == 0) ? 13'd4096 : DIM_W'($urandom_range(25, 8191));
            h = DIM_W'($urandom_range(1, 3));
          end
          9: begin
            w = DIM_W'($urandom_range(1, 3));
            h = ($urandom_range(0, 2) == 0) ? 13'h1FFF :
                ($urandom_range(0, 1) == 0) ? 13'd4096 : DIM_W'($urandom_range(25, 8191));
          end
          default: begin
            w = DIM_W'($urandom_range(0, 24));
            h = DIM_W'($urandom_range(0, 20));
          end
        endcase
        tries++;
      end while (!geometry_is_safe(w, h) && tries < 8);
      // Column zero is always written by now, so a single-column image is always safe.
      if (!geometry_is_safe(w, h)) w = 13'd1;
      set_geometry(w, h);
      n = $urandom_range(4, 40);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) send_pixel(pick_channel(), pick_channel(), pick_channel());
      sent += n;
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  // Reset, directed cases, random images, then drain and report.
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_WIDTH;
    cfg_data     <= '0;
    pix.valid    <= 1'b0;
    pix.in_red   <= '0;
    pix.in_green <= '0;
    pix.in_blue  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_unit_tiles();
    test_clipped_tile();
    test_extreme_geometry();
    test_average_saturation();
    test_sum_wrap();
    test_random_images();

    wait_idle();
    if (errors == 0) begin
      $display("** block_average_pixelate_unit: PASSED **");
    end else begin
      $display("** block_average_pixelate_unit: FAILED **");
    end
    $finish;
  end

endmodule
